>>> hw/rtl/clockwise_most_neighbor_select_assert.svh
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: assertion macros
// Short forms for the concurrent checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef CLOCKWISE_MOST_NEIGHBOR_SELECT_ASSERT_SVH
`define CLOCKWISE_MOST_NEIGHBOR_SELECT_ASSERT_SVH

// Checked only while the block is out of reset.
`define CMNS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cmns assertion failed");

// Checked at every edge, reset included.
`define CMNS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cmns assertion failed during reset");

`endif

>>> hw/rtl/cmns_pkg.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: package
// Widths, item types and the queue entry shared by the front and back parts.
// ----------------------------------------------------------------------------
package cmns_pkg;

    localparam int INDEX_BITS = 16;
    localparam int COORD_BITS = 24;

    typedef logic signed [COORD_BITS-1:0]   t_coord;
    typedef logic signed [2*COORD_BITS-1:0] t_prod;
    typedef logic [INDEX_BITS-1:0]          t_index;

    // Direction used when the query has no incoming vertex: (0, -1).
    localparam t_coord DEF_DIR_X = '0;
    localparam t_coord DEF_DIR_Y = '1;

    localparam logic OP_CW  = 1'b0;
    localparam logic OP_CCW = 1'b1;

    typedef struct packed {
        logic   op;
        logic   query_start;
        logic   has_previous;
        t_coord back_dx;
        t_coord back_dy;
        logic   present;
        logic   neighbour_is_previous;
        t_index neighbour_index;
        t_coord neighbour_dx;
        t_coord neighbour_dy;
        logic   last;
    } t_in_item;

    typedef struct packed {
        logic   found;
        t_index chosen_index;
    } t_out_item;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic   start;
        logic   mode;
        logic   eligible;
        logic   cur_pos;   // sign of cross(cur, a) is positive
        logic   cur_neg;   // sign of cross(cur, a) is negative
        t_index index;
        t_coord dx;
        t_coord dy;
        logic   last;
    } t_q_entry;

endpackage

>>> hw/rtl/cmns_if.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: channel interfaces
// Valid/ready channels for neighbor items and for query results.
// ----------------------------------------------------------------------------
interface cmns_in_if import cmns_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cmns_out_if import cmns_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/cmns_front.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: front part
// Accepts items, tracks the query direction and classifies each neighbor.
// ----------------------------------------------------------------------------
module cmns_front import cmns_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cmns_in_if.sink  i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    logic   r_mode, n_mode;
    logic   r_prev, n_prev;
    t_coord r_dir_x, n_dir_x;
    t_coord r_dir_y, n_dir_y;
    t_prod  w_p;
    t_prod  w_q;
    t_in_item w_it;

    // No transfer is taken while the block is held in reset.
    assign w_it       = i_in.data;
    assign i_in.ready = i_rst_n && !i_full;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        n_mode  = r_mode;
        n_prev  = r_prev;
        n_dir_x = r_dir_x;
        n_dir_y = r_dir_y;
        if (w_it.query_start) begin
            n_mode = w_it.op;
            n_prev = w_it.has_previous;
            if (w_it.has_previous) begin
                n_dir_x = w_it.back_dx;
                n_dir_y = w_it.back_dy;
            end else begin
                n_dir_x = DEF_DIR_X;
                n_dir_y = DEF_DIR_Y;
            end
        end
    end

    // cross(cur, a) = cur.x * a.y - cur.y * a.x, compared as two exact products.
    assign w_p = n_dir_x * w_it.neighbour_dy;
    assign w_q = n_dir_y * w_it.neighbour_dx;

    always_comb begin
        o_entry.start    = w_it.query_start;
        o_entry.mode     = n_mode;
        o_entry.eligible = w_it.present && !(n_prev && w_it.neighbour_is_previous);
        o_entry.cur_pos  = w_p > w_q;
        o_entry.cur_neg  = w_p < w_q;
        o_entry.index    = w_it.neighbour_index;
        o_entry.dx       = w_it.neighbour_dx;
        o_entry.dy       = w_it.neighbour_dy;
        o_entry.last     = w_it.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= OP_CW;
            r_prev  <= 1'b0;
            r_dir_x <= '0;
            r_dir_y <= '0;
        end else if (o_push) begin
            r_mode  <= n_mode;
            r_prev  <= n_prev;
            r_dir_x <= n_dir_x;
            r_dir_y <= n_dir_y;
        end
    end

endmodule

>>> hw/rtl/cmns_queue.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: decoupling queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module cmns_queue import cmns_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_valid,
    output t_q_entry o_entry
);

    t_q_entry   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/cmns_back.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: back part
// Holds the best candidate, applies the selection rules and issues results.
// ----------------------------------------------------------------------------
module cmns_back import cmns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_q_entry   i_entry,
    output logic       o_pop,
    cmns_out_if.source o_out
);

    t_coord r_best_x;
    t_coord r_best_y;
    t_index r_best_idx, n_best_idx;
    logic   r_have, n_have;
    logic   r_convex, n_convex;
    logic   n_take;
    logic   w_have;
    t_index w_idx;
    t_prod  w_p;
    t_prod  w_q;
    logic   w_bpos;
    logic   w_bneg;
    logic   w_sel;

    logic      r_out_valid;
    t_out_item r_out;

    assign o_pop       = i_valid && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // A query start clears the candidate before this item is considered.
    assign w_have = r_have && !i_entry.start;
    assign w_idx  = i_entry.start ? '0 : r_best_idx;

    // cross(best, a); cross(a, best) is its negation.
    assign w_p    = r_best_x * i_entry.dy;
    assign w_q    = r_best_y * i_entry.dx;
    assign w_bpos = w_p > w_q;
    assign w_bneg = w_p < w_q;

    always_comb begin
        if (i_entry.mode == OP_CW) begin
            if (r_convex) begin
                w_sel = w_bpos && i_entry.cur_neg;
            end else begin
                w_sel = i_entry.cur_neg || w_bpos;
            end
        end else begin
            if (r_convex) begin
                w_sel = i_entry.cur_pos || w_bneg;
            end else begin
                w_sel = w_bneg && i_entry.cur_pos;
            end
        end
    end

    always_comb begin
        n_take = 1'b0;
        if (i_entry.eligible) begin
            if (!w_have) begin
                n_take = 1'b1;
            end else if (i_entry.index != w_idx) begin
                n_take = w_sel;
            end
        end
        n_have     = w_have || n_take;
        n_best_idx = n_take ? i_entry.index : w_idx;
        // The new candidate is convex when cross(a, cur) >= 0.
        n_convex   = n_take ? !i_entry.cur_pos : (r_convex && !i_entry.start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_x   <= '0;
            r_best_y   <= '0;
            r_best_idx <= '0;
            r_have     <= 1'b0;
            r_convex   <= 1'b0;
        end else if (o_pop) begin
            r_best_idx <= n_best_idx;
            r_have     <= n_have;
            r_convex   <= n_convex;
            if (n_take) begin
                r_best_x <= i_entry.dx;
                r_best_y <= i_entry.dy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_out.found        <= n_have;
            r_out.chosen_index <= n_have ? n_best_idx : '0;
        end
    end

endmodule

>>> hw/rtl/clockwise_most_neighbor_select.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: top level
// Picks the clockwise-most or counterclockwise-most neighbor of a vertex.
// ----------------------------------------------------------------------------
// Neighbor items stream in one per cycle while the queue has room; the first
// item of a query sets the mode and the incoming direction, and the last one
// yields a result (found flag and chosen index) via the queue and the output
// register. Throughput is one item per clock when nothing stalls: the front
// part forms the sign of cross(direction, neighbor) from two 24x24 products as
// it accepts an item, and the back part forms cross(best, neighbor) against
// its held candidate and updates it in the same cycle. A two-entry queue and
// the output register let input and output stall independently.
module clockwise_most_neighbor_select import cmns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmns_in_if.sink    i_in,
    cmns_out_if.source o_out
);

    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_q_valid;
    t_q_entry w_push_entry;
    t_q_entry w_head;

    cmns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    cmns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head)
    );

    cmns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_entry (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> hw/rtl/cmns_checker.sv
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "clockwise_most_neighbor_select_assert.svh"

module cmns_checker import cmns_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    `CMNS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `CMNS_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data))
    `CMNS_ASSERT(a_none_zero, i_clk, i_rst_n, i_out_valid && !i_out_data.found |-> i_out_data.chosen_index == '0)
    `CMNS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind clockwise_most_neighbor_select cmns_checker u_cmns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clockwise-most neighbor select: testbench
// Sends a table of hand-built queries, then random neighbor walks. A local
// model of the selection (or a result typed into the row) predicts each
// result. Each output is checked; both sides stall at random, bar the last third.
// ----------------------------------------------------------------------------
module testbench;
    import cmns_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 427;
    localparam int N_DIRECTED   = 23;

    typedef struct {
        logic op;
        bit   start;
        bit   prev;
        int   bx;
        int   by;
        bit   pres;
        bit   isprev;
        int   idx;
        int   nx;
        int   ny;
        bit   last;
        bit   typed;   // expected result written into the row
        bit   found;
        int   chosen;
    } t_row;

    // op, start, prev, back x/y, present, is-previous, index, neighbor x/y,
    // last, typed, found, chosen index
    t_row directed [N_DIRECTED] = '{
        // No start after reset: held direction is (0,0) and there is no candidate.
        '{OP_CW,  0, 0, 0, 0, 1, 0, 5, 1, 0, 1, 1, 1, 5},
        // Empty adjacency list.
        '{OP_CW,  1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
        // The only neighbor is the incoming vertex, so nothing is chosen.
        '{OP_CCW, 1, 1, 8388607, -8388608, 1, 1, 77, 8388607, -8388608, 1,
          1, 0, 0},
        // Without a previous vertex the flag is ignored.
        '{OP_CW,  1, 0, -8388608, 8388607, 1, 1, 65535, 8388607, -8388608, 1,
          1, 1, 65535},
        // Clockwise walk arriving from the left.
        '{OP_CW,  1, 1, -1, 0, 1, 0, 10, 1, 0, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 0, 11, 0, 1, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 0, 12, 0, -1, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 1, 3, -1, 0, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 0, 13, 1, 1, 1, 0, 0, 0},
        // The same neighbors, counterclockwise.
        '{OP_CCW, 1, 1, -1, 0, 1, 0, 10, 1, 0, 0, 0, 0, 0},
        '{OP_CCW, 0, 0, 0, 0, 1, 0, 11, 0, 1, 0, 0, 0, 0},
        '{OP_CCW, 0, 0, 0, 0, 1, 0, 12, 0, -1, 0, 0, 0, 0},
        '{OP_CCW, 0, 0, 0, 0, 1, 1, 3, -1, 0, 0, 0, 0, 0},
        '{OP_CCW, 0, 0, 0, 0, 1, 0, 13, 1, 1, 1, 0, 0, 0},
        // A second item with the candidate's index is ignored.
        '{OP_CW,  1, 1, 0, 1, 1, 0, 20, 1, 0, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 0, 20, -1, -1, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 0, 21, -1, 0, 1, 0, 0, 0},
        // Zero-length incoming direction and a zero-length neighbor.
        '{OP_CCW, 1, 1, 0, 0, 1, 0, 30, 0, 0, 0, 0, 0, 0},
        '{OP_CCW, 0, 0, 0, 0, 1, 0, 31, 3, -2, 1, 0, 0, 0},
        // After a result the held state carries on without a start.
        '{OP_CCW, 0, 0, 0, 0, 1, 0, 32, -5, 7, 1, 0, 0, 0},
        // Coordinates at the ends of their range.
        '{OP_CW,  1, 1, -8388608, -8388608, 1, 0, 0, 8388607, 8388607, 0,
          0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 1, 0, 1, -8388608, 8388607, 0, 0, 0, 0},
        '{OP_CW,  0, 0, 0, 0, 0, 0, 65535, -8388608, -8388608, 1, 0, 0, 0}
    };

    logic i_clk;
    logic i_rst_n;

    cmns_in_if  in_if ();
    cmns_out_if out_if ();

    clockwise_most_neighbor_select DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Local copy of the selector state.
    t_coord dir_x, dir_y, cand_x, cand_y;
    t_index cand_idx;
    logic   have_cand, cand_convex, mode_ccw, prev_valid;

    t_out_item expected_results [$];
    int        errors;
    int        cycles = 0;
    int        src_idle_pct;
    int        snk_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Sign of a.x*b.y - a.y*b.x, exact in 64 bits.
    function automatic int cross_sign(input t_coord ax, input t_coord ay,
                                      input t_coord bx, input t_coord by);
        longint p;
        longint q;
        p = longint'(ax) * longint'(by);
        q = longint'(ay) * longint'(bx);
        return (p > q) ? 1 : ((p < q) ? -1 : 0);
    endfunction

    function automatic void take_candidate(input t_coord x, input t_coord y,
                                           input t_index idx);
        cand_x      = x;
        cand_y      = y;
        cand_idx    = idx;
        have_cand   = 1'b1;
        cand_convex = cross_sign(x, y, dir_x, dir_y) >= 0;
    endfunction

    // Advances the selector by one item; returns 1 when a result is due.
    function automatic bit select_neighbor(input t_in_item it, output t_out_item res);
        t_coord ax;
        t_coord ay;
        bit     pick;
        ax = it.neighbour_dx;
        ay = it.neighbour_dy;
        if (it.query_start) begin
            mode_ccw   = it.op;
            prev_valid = it.has_previous;
            if (it.has_previous) begin
                dir_x = it.back_dx;
                dir_y = it.back_dy;
            end else begin
                dir_x = '0;
                dir_y = -1;
            end
            have_cand   = 1'b0;
            cand_convex = 1'b0;
            cand_x      = '0;
            cand_y      = '0;
            cand_idx    = '0;
        end
        if (it.present && !(prev_valid && it.neighbour_is_previous)) begin
            if (!have_cand) begin
                take_candidate(ax, ay, it.neighbour_index);
            end else if (it.neighbour_index != cand_idx) begin
                if (mode_ccw == OP_CW) begin
                    if (cand_convex)
                        pick = cross_sign(cand_x, cand_y, ax, ay) > 0 &&
                               cross_sign(ax, ay, dir_x, dir_y) > 0;
                    else
                        pick = cross_sign(dir_x, dir_y, ax, ay) < 0 ||
                               cross_sign(ax, ay, cand_x, cand_y) < 0;
                end else begin
                    if (cand_convex)
                        pick = cross_sign(dir_x, dir_y, ax, ay) > 0 ||
                               cross_sign(ax, ay, cand_x, cand_y) > 0;
                    else
                        pick = cross_sign(cand_x, cand_y, ax, ay) < 0 &&
                               cross_sign(ax, ay, dir_x, dir_y) < 0;
                end
                if (pick)
                    take_candidate(ax, ay, it.neighbour_index);
            end
        end
        res.found        = have_cand;
        res.chosen_index = have_cand ? cand_idx : '0;
        return it.last;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom);
            1: return t_coord'(int'($urandom_range(0, 8)) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0: return t_coord'(-8388608);
                    1: return t_coord'(8388607);
                    2: return '0;
                    default: return t_coord'(-1);
                endcase
            end
            default: return t_coord'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic t_in_item rand_neighbor_item(input bit first, input bit final_item);
        t_in_item it;
        it.op                    = $urandom_range(0, 1) ? OP_CCW : OP_CW;
        it.query_start           = first;
        it.has_previous          = $urandom_range(0, 3) != 0;
        it.back_dx               = rand_coord();
        it.back_dy               = rand_coord();
        it.present               = $urandom_range(0, 9) != 0;
        it.neighbour_is_previous = $urandom_range(0, 7) == 0;
        it.neighbour_index       = $urandom_range(0, 1) ? t_index'($urandom_range(0, 7))
                                                        : t_index'($urandom);
        it.neighbour_dx          = rand_coord();
        it.neighbour_dy          = rand_coord();
        it.last                  = final_item;
        return it;
    endfunction

    // Sends one item and records the result it should cause once it transfers.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        if (select_neighbor(it, res))
            expected_results.push_back(typed ? want : res);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: found %0d chosen_index %0d",
                   got.found, got.chosen_index);
            errors++;
        end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.chosen_index !== want.chosen_index) begin
                $error("chosen_index: expected %0d, actual %0d",
                       want.chosen_index, got.chosen_index);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready)
                check_result(out_if.data);
            out_if.ready <= $urandom_range(0, 99) >= snk_idle_pct;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item want;
        t_row      r;
        int        sent;
        int        len;
        bit        noise;
        bit        broken;

        errors       = 0;
        sent         = 0;
        src_idle_pct = 14;
        snk_idle_pct = 88;
        dir_x        = '0;
        dir_y        = '0;
        cand_x       = '0;
        cand_y       = '0;
        cand_idx     = '0;
        have_cand    = 1'b0;
        cand_convex  = 1'b0;
        mode_ccw     = 1'b0;
        prev_valid   = 1'b0;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            r = directed[i];
            it.op                    = r.op;
            it.query_start           = r.start;
            it.has_previous          = r.prev;
            it.back_dx               = t_coord'(r.bx);
            it.back_dy               = t_coord'(r.by);
            it.present               = r.pres;
            it.neighbour_is_previous = r.isprev;
            it.neighbour_index       = t_index'(r.idx);
            it.neighbour_dx          = t_coord'(r.nx);
            it.neighbour_dy          = t_coord'(r.ny);
            it.last                  = r.last;
            want.found               = r.found;
            want.chosen_index        = t_index'(r.chosen);
            send_item(it, r.typed, want);
        end

        // Mostly well-formed walks; some lose their start, some are pure noise.
        while (sent < RANDOM_ITEMS) begin
            len    = $urandom_range(1, 6);
            noise  = $urandom_range(0, 9) == 0;
            broken = $urandom_range(0, 11) == 0;
            for (int k = 0; k < len; k++) begin
                if (sent >= 2 * RANDOM_ITEMS / 3) begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end else if (sent >= RANDOM_ITEMS / 3) begin
                    src_idle_pct = 88;
                    snk_idle_pct = 14;
                end
                it = rand_neighbor_item(k == 0 && !broken, k == len - 1);
                if (noise) begin
                    it.query_start = $urandom_range(0, 1);
                    it.last        = $urandom_range(0, 1);
                end
                if (it.present || it.last || it.query_start)
                    sent++;
                send_item(it, 1'b0, want);
            end
        end
        in_if.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
